// ----- hw/rtl/tilt_pkg.sv -----
// Shared widths, CORDIC angle table and stage types for the tilt angle pipeline.
package tilt_pkg;

	// Input sample and squared-magnitude widths
	localparam int AXIS_W = 16;
	localparam int SQ_W   = 2 * AXIS_W;
	localparam int AZ_W   = AXIS_W;
	localparam int DEG_W  = 8;
	localparam int MAG_W  = DEG_W - 1;

	// Square root: 8 fractional bits on a 32-bit square gives a 24-bit root
	localparam int ROOT_FRAC       = 8;
	localparam int ROOT_W          = AXIS_W + ROOT_FRAC;
	localparam int REM_W           = ROOT_W + 2;
	localparam int SQRT_PER_STAGE  = 2;
	localparam int SQRT_STAGES     = ROOT_W / SQRT_PER_STAGE;

	// CORDIC datapath
	localparam int CORDIC_STAGES    = 16;
	localparam int ANGLE_TABLE_SIZE = 24;
	localparam int ANGLE_FRAC       = 16;
	localparam int X_W              = ROOT_W + 4;
	localparam int ACC_W            = 26;

	localparam int HALF_TURN_DEG   = 180;
	localparam int RIGHT_ANGLE_DEG = HALF_TURN_DEG / 2;
	localparam logic signed [ACC_W-1:0] RIGHT_ANGLE_FIX =
		ACC_W'(RIGHT_ANGLE_DEG * (1 << ANGLE_FRAC));

	// atan(2^-i) in degrees, 16 fractional bits
	localparam logic signed [ACC_W-1:0] STEP_ANGLE [ANGLE_TABLE_SIZE] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
		26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
		26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
		26'sd917,     26'sd458,     26'sd229,    26'sd115,
		26'sd57,      26'sd29,      26'sd14,     26'sd7,
		26'sd4,       26'sd2,       26'sd1,      26'sd0
	};

	// Digit-by-digit square root state
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [SQ_W-1:0]   n;
	} rt_state_t;

	// CORDIC vector and angle accumulator
	typedef struct packed {
		logic signed [X_W-1:0]   x;
		logic signed [X_W-1:0]   y;
		logic signed [ACC_W-1:0] acc;
	} cd_state_t;

	// Flags that ride along with the CORDIC vector
	typedef struct packed {
		logic zneg;
		logic azero;
		logic hnz;
	} cd_flags_t;

endpackage

// ----- hw/rtl/accel_tilt_angle.sv -----
// Accelerometer tilt angle: squares, pipelined integer square root, vectoring CORDIC.
// Throughput: one sample per cycle while sample_stall is low; each root digit pair and CORDIC turn has its own stage.
// A two-entry output buffer lets the pipeline keep running under output stall until the skid entry fills.
// Reset (arst_n low) clears all valid bits and the output buffer; data registers are not reset.
module accel_tilt_angle
	import tilt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  logic signed [AXIS_W-1:0] accel_x,
	input  logic signed [AXIS_W-1:0] accel_y,
	input  logic signed [AXIS_W-1:0] accel_z,
	output logic                    pitch_valid,
	input  logic                    pitch_stall,
	output logic signed [DEG_W-1:0]  pitch_degrees
);

	// One square-root iteration: bring down two bits, try to subtract 4q+1
	function automatic rt_state_t rt_iter(input rt_state_t s);
		logic [REM_W+1:0] rsh;
		logic [REM_W+1:0] trial;
		rt_state_t        r;
		rsh   = {s.rem, s.n[SQ_W-1 -: 2]};
		trial = {{(REM_W - ROOT_W){1'b0}}, s.root, 2'b01};
		r.n   = {s.n[SQ_W-3:0], 2'b00};
		if (rsh >= trial) begin
			r.rem  = REM_W'(rsh - trial);
			r.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = rsh[REM_W-1:0];
			r.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	logic en;
	logic skid_vld_q;

	// Whole pipeline moves together; it freezes only when the skid entry is occupied
	assign en           = !skid_vld_q;
	assign sample_stall = skid_vld_q;

	// Stage 1: squares and |z|
	logic                   vld_s1;
	logic [SQ_W-1:0]        xsq_s1;
	logic [SQ_W-1:0]        ysq_s1;
	logic [AZ_W-1:0]        az_s1;
	logic                   zneg_s1;
	logic signed [SQ_W-1:0] xprod;
	logic signed [SQ_W-1:0] yprod;

	assign xprod = accel_x * accel_x;
	assign yprod = accel_y * accel_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xsq_s1  <= $unsigned(xprod);
			ysq_s1  <= $unsigned(yprod);
			az_s1   <= accel_z[AXIS_W-1] ? AZ_W'(-accel_z) : $unsigned(accel_z);
			zneg_s1 <= accel_z[AXIS_W-1];
		end
	end

	// Square-root pipeline; index 0 is the stage that sums the squares
	rt_state_t       rt_s    [SQRT_STAGES+1];
	logic            rt_vld_s[SQRT_STAGES+1];
	logic [AZ_W-1:0] rt_az_s [SQRT_STAGES+1];
	logic            rt_zn_s [SQRT_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_vld_s[0] <= 1'b0;
		end else if (en) begin
			rt_vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[0].n    <= xsq_s1 + ysq_s1;
			rt_s[0].rem  <= '0;
			rt_s[0].root <= '0;
			rt_az_s[0]   <= az_s1;
			rt_zn_s[0]   <= zneg_s1;
		end
	end

	for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_sqrt
		rt_state_t nxt;

		// SQRT_PER_STAGE root digits per stage
		always_comb begin
			nxt = rt_s[k-1];
			for (int j = 0; j < SQRT_PER_STAGE; j++) begin
				nxt = rt_iter(nxt);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else if (en) begin
				rt_vld_s[k] <= rt_vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k]    <= nxt;
				rt_az_s[k] <= rt_az_s[k-1];
				rt_zn_s[k] <= rt_zn_s[k-1];
			end
		end
	end

	// CORDIC start vector (|z| << 8, h) and the flags that ride with it
	cd_state_t cd_start;
	cd_flags_t fl_start;

	always_comb begin
		cd_start.x   = {{(X_W - AZ_W - ROOT_FRAC){1'b0}}, rt_az_s[SQRT_STAGES],
			{ROOT_FRAC{1'b0}}};
		cd_start.y   = {{(X_W - ROOT_W){1'b0}}, rt_s[SQRT_STAGES].root};
		cd_start.acc = '0;
		fl_start.zneg  = rt_zn_s[SQRT_STAGES];
		fl_start.azero = (rt_az_s[SQRT_STAGES] == '0);
		fl_start.hnz   = (rt_s[SQRT_STAGES].root != '0);
	end

	// CORDIC pipeline; entry i holds the vector after turn i
	cd_state_t cd_s    [CORDIC_STAGES];
	cd_flags_t cd_fl_s [CORDIC_STAGES];
	logic      cd_vld_s[CORDIC_STAGES];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		cd_state_t             cur;
		cd_flags_t             cur_fl;
		logic                  cur_vld;
		logic signed [X_W-1:0] dx;
		logic signed [X_W-1:0] dy;
		cd_state_t             nxt;

		if (i == 0) begin : g_head
			assign cur     = cd_start;
			assign cur_fl  = fl_start;
			assign cur_vld = rt_vld_s[SQRT_STAGES];
		end else begin : g_body
			assign cur     = cd_s[i-1];
			assign cur_fl  = cd_fl_s[i-1];
			assign cur_vld = cd_vld_s[i-1];
		end

		// Turn toward the x axis; no turn when y is exactly zero
		always_comb begin
			dx  = cur.y >>> i;
			dy  = cur.x >>> i;
			nxt = cur;
			if (cur.y[X_W-1]) begin
				nxt.x   = cur.x - dx;
				nxt.y   = cur.y + dy;
				nxt.acc = cur.acc - STEP_ANGLE[i];
			end else if (cur.y != '0) begin
				nxt.x   = cur.x + dx;
				nxt.y   = cur.y - dy;
				nxt.acc = cur.acc + STEP_ANGLE[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cd_vld_s[i] <= 1'b0;
			end else if (en) begin
				cd_vld_s[i] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cd_s[i]    <= nxt;
				cd_fl_s[i] <= cur_fl;
			end
		end
	end

	// Clamp, take whole degrees, apply the sign of z
	logic [MAG_W-1:0]        mag;
	logic signed [DEG_W-1:0] deg;
	cd_state_t               cd_last;
	cd_flags_t               fl_last;

	assign cd_last = cd_s[CORDIC_STAGES-1];
	assign fl_last = cd_fl_s[CORDIC_STAGES-1];

	always_comb begin
		if (fl_last.azero) begin
			mag = fl_last.hnz ? MAG_W'(RIGHT_ANGLE_DEG) : '0;
		end else if (cd_last.acc[ACC_W-1]) begin
			mag = '0;
		end else if (cd_last.acc > RIGHT_ANGLE_FIX) begin
			mag = MAG_W'(RIGHT_ANGLE_DEG);
		end else begin
			mag = cd_last.acc[ANGLE_FRAC +: MAG_W];
		end
		deg = fl_last.zneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	// Output register plus one skid entry
	logic                    out_vld_q;
	logic signed [DEG_W-1:0] pitch_q;
	logic signed [DEG_W-1:0] skid_deg_q;
	logic                    out_free;
	logic                    load_from_skid;
	logic                    load_from_pipe;
	logic                    load_skid;

	assign out_free       = !out_vld_q || !pitch_stall;
	assign load_from_skid = skid_vld_q && out_free;
	assign load_from_pipe = !skid_vld_q && cd_vld_s[CORDIC_STAGES-1] && out_free;
	assign load_skid      = !skid_vld_q && cd_vld_s[CORDIC_STAGES-1] && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (load_from_skid || load_from_pipe) begin
				out_vld_q <= 1'b1;
			end else if (out_free) begin
				out_vld_q <= 1'b0;
			end
			if (load_skid) begin
				skid_vld_q <= 1'b1;
			end else if (load_from_skid) begin
				skid_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_from_skid) begin
			pitch_q <= skid_deg_q;
		end else if (load_from_pipe) begin
			pitch_q <= deg;
		end
		if (load_skid) begin
			skid_deg_q <= deg;
		end
	end

	assign pitch_valid   = out_vld_q;
	assign pitch_degrees = pitch_q;

endmodule
